>>> rtl/core/ckpe_pkg.sv
// Shared types and constants for the color-keyed pixel expander.
// Used by every module of the block; depends on nothing else.
package ckpe_pkg;

  // Raster geometry.
  localparam int unsigned PosW = 11;
  localparam int unsigned DimW = 12;
  localparam logic [DimW-1:0] MaxDim = 12'd2048;
  localparam logic [DimW-1:0] ResetWidth = 12'd640;
  localparam logic [DimW-1:0] ResetHeight = 12'd480;

  // Pixel format and key.
  localparam int unsigned ModeW = 4;
  localparam logic [15:0] ColorKey = 16'h07FF;

  localparam logic [ModeW-1:0] Mode565 = 4'd0;
  localparam logic [ModeW-1:0] Mode555 = 4'd1;
  localparam logic [ModeW-1:0] Mode1555 = 4'd2;
  localparam logic [ModeW-1:0] Mode565Depth = 4'd12;
  localparam logic [ModeW-1:0] Mode555Depth = 4'd13;
  localparam logic [ModeW-1:0] Mode1555Depth = 4'd14;
  localparam logic [ModeW-1:0] ModeDepthOnly = 4'd15;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgWriteMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd2;

  typedef struct packed {
    logic            frame_last;
    logic            box_valid;
    logic [PosW-1:0] box_left;
    logic [PosW-1:0] box_top;
    logic [DimW-1:0] box_right;
    logic [DimW-1:0] box_bottom;
  } box_t;

  // A dimension of zero acts as one, anything above the maximum as the maximum.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = {{(DimW-1){1'b0}}, 1'b1};
    end else if (v > MaxDim) begin
      r = MaxDim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ckpe_convert.sv
// Pixel format expansion and color-key test for one item.
// Depends on ckpe_pkg.
module ckpe_convert import ckpe_pkg::*; (
  input  logic [31:0]      pixel_word_i,
  input  logic [ModeW-1:0] write_mode_i,
  output logic [31:0]      color_o,
  output logic             drawn_o
);

  logic [15:0] p;
  logic [31:0] expanded;

  assign p = pixel_word_i[15:0];
  assign drawn_o = (p != ColorKey);

  // Narrow channels are widened by repeating their top bits at the bottom.
  always_comb begin
    unique case (write_mode_i) inside
      Mode565, Mode565Depth: begin
        expanded = {8'h00, p[4:0], p[4:2], p[10:5], p[10:9], p[15:11], p[15:13]};
      end
      Mode555, Mode1555, Mode555Depth, Mode1555Depth: begin
        expanded = {{8{~p[15]}}, p[4:0], p[4:2], p[9:5], p[9:7], p[14:10], p[14:12]};
      end
      ModeDepthOnly: begin
        expanded = '1;
      end
      default: begin
        expanded = {8'h00, pixel_word_i[7:0], pixel_word_i[15:8], pixel_word_i[23:16]};
      end
    endcase
  end

  assign color_o = drawn_o ? expanded : '1;

endmodule

>>> rtl/core/ckpe_bbox.sv
// Raster position tracking and bounding box of drawn pixels.
// Depends on ckpe_pkg.
module ckpe_bbox import ckpe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            drawn_i,
  input  logic [DimW-1:0] frame_width_i,
  input  logic [DimW-1:0] frame_height_i,
  output box_t            box_o
);

  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic [DimW-1:0] least_col_q, least_col_d, least_row_q, least_row_d;
  logic [PosW-1:0] great_col_q, great_col_d, great_row_q, great_row_d;
  logic [DimW-1:0] eff_w, eff_h;
  logic [DimW-1:0] col_inc, row_inc;
  logic            row_end, last;
  logic [DimW-1:0] lc_n, lr_n;
  logic [PosW-1:0] gc_n, gr_n;

  assign eff_w = clamp_dim(frame_width_i);
  assign eff_h = clamp_dim(frame_height_i);
  assign col_inc = {1'b0, col_q} + DimW'(1);
  assign row_inc = {1'b0, row_q} + DimW'(1);
  assign row_end = (col_inc >= eff_w);
  assign last = row_end && (row_inc >= eff_h);

  // Box including the current item.
  always_comb begin
    lc_n = least_col_q;
    lr_n = least_row_q;
    gc_n = great_col_q;
    gr_n = great_row_q;
    if (drawn_i) begin
      if (col_q > great_col_q) gc_n = col_q;
      if (row_q > great_row_q) gr_n = row_q;
      if ({1'b0, col_q} < least_col_q) lc_n = {1'b0, col_q};
      if ({1'b0, row_q} < least_row_q) lr_n = {1'b0, row_q};
    end
  end

  always_comb begin
    box_o = '0;
    box_o.frame_last = last;
    if (last && ({1'b0, gc_n} >= lc_n)) begin
      box_o.box_valid = 1'b1;
      box_o.box_left = lc_n[PosW-1:0];
      box_o.box_top = lr_n[PosW-1:0];
      box_o.box_right = {1'b0, gc_n} + DimW'(1);
      box_o.box_bottom = {1'b0, gr_n} + DimW'(1);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    least_col_d = least_col_q;
    least_row_d = least_row_q;
    great_col_d = great_col_q;
    great_row_d = great_row_q;
    if (advance_i) begin
      least_col_d = lc_n;
      least_row_d = lr_n;
      great_col_d = gc_n;
      great_row_d = gr_n;
      if (row_end) begin
        col_d = '0;
        if (last) begin
          row_d = '0;
          least_col_d = eff_w;
          least_row_d = eff_h;
          great_col_d = '0;
          great_row_d = '0;
        end else begin
          row_d = row_inc[PosW-1:0];
        end
      end else begin
        col_d = col_inc[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      least_col_q <= ResetWidth;
      least_row_q <= ResetHeight;
      great_col_q <= '0;
      great_row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      least_col_q <= least_col_d;
      least_row_q <= least_row_d;
      great_col_q <= great_col_d;
      great_row_q <= great_row_d;
    end
  end

endmodule

>>> rtl/core/color_keyed_pixel_expander.sv
// Color-keyed pixel expander: converts frame-buffer pixel words to RGBA8888
// and reports the bounding box of drawn pixels on the last pixel of a frame.
// Pipeline: an accepted item goes through the input register, then the result register.
// Throughput: one item per cycle while the output does not stall; the conversion and
// box update sit between the two registers. Reset: asynchronous, active low; clears
// both stages, the raster position, the box and the registers to mode 0, 640 x 480.
module color_keyed_pixel_expander import ckpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        pixel_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        color_out_o,
  output logic               pixel_drawn_o,
  output logic               frame_last_o,
  output logic               box_valid_o,
  output logic [PosW-1:0]    box_left_o,
  output logic [PosW-1:0]    box_top_o,
  output logic [DimW-1:0]    box_right_o,
  output logic [DimW-1:0]    box_bottom_o
);

  logic [ModeW-1:0] mode_q;
  logic [DimW-1:0]  width_q, height_q;
  logic             in_valid_q;
  logic [31:0]      word_q;
  logic             res_valid_q;
  logic [31:0]      color_q, color_d;
  logic             drawn_q, drawn_d;
  box_t             box_q, box_d;
  logic             res_free, advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= Mode565;
      width_q <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgWriteMode: mode_q <= cfg_data_i[ModeW-1:0];
        CfgFrameWidth: width_q <= cfg_data_i;
        CfgFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The result register frees up when empty or when its item is taken.
  assign res_free = !res_valid_q || !out_stall_i;
  assign advance = in_valid_q && res_free;
  assign in_stall_o = in_valid_q && !res_free;

  ckpe_convert u_convert (
    .pixel_word_i (word_q),
    .write_mode_i (mode_q),
    .color_o      (color_d),
    .drawn_o      (drawn_d)
  );

  ckpe_bbox u_bbox (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .drawn_i        (drawn_d),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .box_o          (box_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (res_free) res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) word_q <= pixel_word_i;
    if (advance) begin
      color_q <= color_d;
      drawn_q <= drawn_d;
      box_q <= box_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign color_out_o = color_q;
  assign pixel_drawn_o = drawn_q;
  assign frame_last_o = box_q.frame_last;
  assign box_valid_o = box_q.box_valid;
  assign box_left_o = box_q.box_left;
  assign box_top_o = box_q.box_top;
  assign box_right_o = box_q.box_right;
  assign box_bottom_o = box_q.box_bottom;

endmodule
